@@ rtl/stpe_pkg.sv @@
`timescale 1ns / 1ps

package stpe_pkg;

	localparam int BYTE_W     = 8;
	localparam int STR_BYTES  = 12;
	localparam int STR_W      = STR_BYTES * BYTE_W;
	localparam int REM_W      = $clog2(STR_BYTES);
	localparam int PAT_W      = 6;
	localparam int USED_W     = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [BYTE_W-1:0] UMLAUT_MARK  = "@";
	localparam logic [BYTE_W-1:0] NEXT_MARK    = "#";
	localparam logic [BYTE_W-1:0] SELF_MARK    = "$";
	localparam logic [BYTE_W-1:0] UMLAUT_RESET = 8'd252;

	// pattern codes
	localparam logic [PAT_W-1:0] PAT_SELF     = 6'd0;
	localparam logic [PAT_W-1:0] PAT_AE_YI    = 6'd1;
	localparam logic [PAT_W-1:0] PAT_AE_OPT   = 6'd2;
	localparam logic [PAT_W-1:0] PAT_A_AH     = 6'd3;
	localparam logic [PAT_W-1:0] PAT_AH       = 6'd4;
	localparam logic [PAT_W-1:0] PAT_CZK_NEXT = 6'd5;
	localparam logic [PAT_W-1:0] PAT_CK_EL    = 6'd6;
	localparam logic [PAT_W-1:0] PAT_CK       = 6'd7;
	localparam logic [PAT_W-1:0] PAT_CK_H     = 6'd8;
	localparam logic [PAT_W-1:0] PAT_AE_YIU_H = 6'd9;
	localparam logic [PAT_W-1:0] PAT_EILF     = 6'd10;
	localparam logic [PAT_W-1:0] PAT_EE_H     = 6'd11;
	localparam logic [PAT_W-1:0] PAT_E_H      = 6'd12;
	localparam logic [PAT_W-1:0] PAT_FP       = 6'd13;
	localparam logic [PAT_W-1:0] PAT_FF       = 6'd14;
	localparam logic [PAT_W-1:0] PAT_HEN      = 6'd15;
	localparam logic [PAT_W-1:0] PAT_H        = 6'd16;
	localparam logic [PAT_W-1:0] PAT_IY_EH    = 6'd17;
	localparam logic [PAT_W-1:0] PAT_IY_CGEH  = 6'd18;
	localparam logic [PAT_W-1:0] PAT_IJ       = 6'd19;
	localparam logic [PAT_W-1:0] PAT_K_CK     = 6'd20;
	localparam logic [PAT_W-1:0] PAT_LL       = 6'd21;
	localparam logic [PAT_W-1:0] PAT_MM       = 6'd22;
	localparam logic [PAT_W-1:0] PAT_NN       = 6'd23;
	localparam logic [PAT_W-1:0] PAT_OE       = 6'd24;
	localparam logic [PAT_W-1:0] PAT_OO       = 6'd25;
	localparam logic [PAT_W-1:0] PAT_OU       = 6'd26;
	localparam logic [PAT_W-1:0] PAT_OH       = 6'd27;
	localparam logic [PAT_W-1:0] PAT_PF       = 6'd28;
	localparam logic [PAT_W-1:0] PAT_PP       = 6'd29;
	localparam logic [PAT_W-1:0] PAT_P        = 6'd30;
	localparam logic [PAT_W-1:0] PAT_SS       = 6'd31;
	localparam logic [PAT_W-1:0] PAT_S_CK     = 6'd32;
	localparam logic [PAT_W-1:0] PAT_S_ZC     = 6'd33;
	localparam logic [PAT_W-1:0] PAT_UE       = 6'd34;
	localparam logic [PAT_W-1:0] PAT_UV       = 6'd35;
	localparam logic [PAT_W-1:0] PAT_TH       = 6'd36;
	localparam logic [PAT_W-1:0] PAT_TZ_IEH   = 6'd37;
	localparam logic [PAT_W-1:0] PAT_TZ_I     = 6'd38;
	localparam logic [PAT_W-1:0] PAT_TT       = 6'd39;
	localparam logic [PAT_W-1:0] PAT_TZ       = 6'd40;
	localparam logic [PAT_W-1:0] PAT_IY_U     = 6'd41;
	localparam logic [PAT_W-1:0] PAT_T_ZC     = 6'd42;

	typedef struct packed {
		logic [BYTE_W-1:0] char_in;
		logic              end_of_word;
		logic              verbatim;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_word;
	} out_t;

	// one letter (or copied byte) waiting to be expanded
	typedef struct packed {
		logic [PAT_W-1:0]  pat;
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] n;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [PAT_W-1:0]  pat;
		logic [USED_W-1:0] used;
	} class_t;

	function automatic class_t classify(input logic [BYTE_W-1:0] c,
		input logic [BYTE_W-1:0] n, input logic [BYTE_W-1:0] n1);
		class_t r;
		r.pat  = PAT_SELF;
		r.used = 2'd0;
		case (c)
			"a": begin
				if (n == "y" || n == "i") begin r.pat = PAT_AE_YI; r.used = 2'd1; end
				else if (n == "e") begin r.pat = PAT_AE_OPT; r.used = 2'd1; end
				else if (n == "a") begin r.pat = PAT_A_AH; r.used = 2'd1; end
				else r.pat = PAT_AH;
			end
			"c": begin
				if (n == "i" || n == "e" || n == "y") begin
					r.pat = PAT_CZK_NEXT; r.used = 2'd1;
				end else if (n == "k" || n == "c") begin
					if (n1 == "l") begin r.pat = PAT_CK_EL; r.used = 2'd2; end
					else begin r.pat = PAT_CK; r.used = 2'd1; end
				end else if (n == "h") begin r.pat = PAT_CK_H; r.used = 2'd1; end
				else r.pat = PAT_CK;
			end
			"e": begin
				if (n == "i" || n == "y") begin r.pat = PAT_AE_YIU_H; r.used = 2'd1; end
				else if (n == "l" && n1 == "f") begin r.pat = PAT_EILF; r.used = 2'd2; end
				else if (n == "e") begin r.pat = PAT_EE_H; r.used = 2'd1; end
				else r.pat = PAT_E_H;
			end
			"f": begin
				if (n == "f") begin r.pat = PAT_FF; r.used = 2'd1; end
				else if (n == "a" || n == "e" || n == "i" || n == "o" || n == "u" ||
					n == "l" || n == "y") r.pat = PAT_FP;
				else r.pat = PAT_FF;
			end
			"h": begin
				if (n == "n") begin r.pat = PAT_HEN; r.used = 2'd1; end
				else if (n == "e" && n1 == "n") begin r.pat = PAT_HEN; r.used = 2'd2; end
				else r.pat = PAT_H;
			end
			"i": begin
				if (n == "e") begin r.pat = PAT_IY_EH; r.used = 2'd1; end
				else if (n == "g") begin r.pat = PAT_IY_CGEH; r.used = 2'd1; end
				else r.pat = PAT_IY_EH;
			end
			"j": r.pat = PAT_IJ;
			"k": begin
				if (n == "k") begin r.pat = PAT_CK; r.used = 2'd1; end
				else if (n == "c") begin r.pat = PAT_K_CK; r.used = 2'd1; end
				else r.pat = PAT_CK_H;
			end
			"l": begin r.pat = PAT_LL; r.used = {1'b0, n == "l"}; end
			"m": begin r.pat = PAT_MM; r.used = {1'b0, n == "m"}; end
			"n": begin r.pat = PAT_NN; r.used = {1'b0, n == "n"}; end
			"o": begin
				if (n == "e") begin r.pat = PAT_OE; r.used = 2'd1; end
				else if (n == "o") begin r.pat = PAT_OO; r.used = 2'd1; end
				else if (n == "u") begin r.pat = PAT_OU; r.used = 2'd1; end
				else r.pat = PAT_OH;
			end
			"p": begin
				if (n == "h") begin r.pat = PAT_PF; r.used = 2'd1; end
				else if (n == "p") begin r.pat = PAT_PP; r.used = 2'd1; end
				else r.pat = PAT_P;
			end
			"s": begin
				if (n == "s") begin r.pat = PAT_SS; r.used = 2'd1; end
				else if (n == "c") begin r.pat = PAT_S_CK; r.used = 2'd1; end
				else if (n == "z") begin r.pat = PAT_S_ZC; r.used = 2'd1; end
				else r.pat = PAT_SS;
			end
			"u": begin
				if (n == "e") begin r.pat = PAT_UE; r.used = 2'd1; end
				else r.pat = PAT_UV;
			end
			"t": begin
				if (n == "h") begin r.pat = PAT_TH; r.used = 2'd1; end
				else if (n == "i") begin
					if (n1 == "e") begin r.pat = PAT_TZ_IEH; r.used = 2'd2; end
					else begin r.pat = PAT_TZ_I; r.used = 2'd1; end
				end else if (n == "t") begin r.pat = PAT_TT; r.used = 2'd1; end
				else if (n == "z") begin r.pat = PAT_TZ; r.used = 2'd1; end
				else r.pat = PAT_TH;
			end
			"y": r.pat = PAT_IY_U;
			"z": r.pat = PAT_T_ZC;
			default: begin
				r.pat  = PAT_SELF;
				r.used = 2'd0;
			end
		endcase
		return r;
	endfunction

	// strings sit right-aligned, zero bytes above the first character
	function automatic logic [STR_W-1:0] pat_str(input logic [PAT_W-1:0] pat);
		logic [STR_W-1:0] s;
		case (pat)
			PAT_SELF:     s = "$";
			PAT_AE_YI:    s = "[ae][yi]";
			PAT_AE_OPT:   s = "ae?";
			PAT_A_AH:     s = "a[ah]?";
			PAT_AH:       s = "ah?";
			PAT_CZK_NEXT: s = "[czk]?#";
			PAT_CK_EL:    s = "[ck]{1,2}e?l";
			PAT_CK:       s = "[ck]{1,2}";
			PAT_CK_H:     s = "[ck]{1,2}h?";
			PAT_AE_YIU_H: s = "[ae][yiu]h?";
			PAT_EILF:     s = "ei?lf";
			PAT_EE_H:     s = "[e]{1,2}h?";
			PAT_E_H:      s = "[e]h?";
			PAT_FP:       s = "[fp]f?h?";
			PAT_FF:       s = "f{1,2}";
			PAT_HEN:      s = "h?e?n";
			PAT_H:        s = "h?";
			PAT_IY_EH:    s = "[i@y][eh]?";
			PAT_IY_CGEH:  s = "[i@y][cgeh]?";
			PAT_IJ:       s = "[ij]";
			PAT_K_CK:     s = "k[ck]{1,2}";
			PAT_LL:       s = "l{1,2}";
			PAT_MM:       s = "m{1,2}";
			PAT_NN:       s = "n{1,2}";
			PAT_OE:       s = "oe?h?";
			PAT_OO:       s = "o{1,2}h?";
			PAT_OU:       s = "o?uh?";
			PAT_OH:       s = "oh?";
			PAT_PF:       s = "[pf]h?";
			PAT_PP:       s = "p{1,2}";
			PAT_P:        s = "p";
			PAT_SS:       s = "s{1,2}";
			PAT_S_CK:     s = "s[ck]?";
			PAT_S_ZC:     s = "s[zc]h?";
			PAT_UE:       s = "ue?h?";
			PAT_UV:       s = "[uv]h?";
			PAT_TH:       s = "th?";
			PAT_TZ_IEH:   s = "[tz]i[eh]?";
			PAT_TZ_I:     s = "[tz]i";
			PAT_TT:       s = "t{1,2}h?";
			PAT_TZ:       s = "t?z";
			PAT_IY_U:     s = "[iy@]";
			PAT_T_ZC:     s = "t?[zc]";
			default:      s = "$";
		endcase
		return s;
	endfunction

	// index of the first (topmost) character, i.e. length minus one
	function automatic logic [REM_W-1:0] pat_top(input logic [PAT_W-1:0] pat);
		logic [STR_W-1:0] s;
		logic [REM_W-1:0] top;
		s   = pat_str(pat);
		top = '0;
		for (int i = 0; i < STR_BYTES; i++) begin
			if (s[i*BYTE_W +: BYTE_W] != '0) top = REM_W'(i);
		end
		return top;
	endfunction

endpackage

@@ rtl/stpe_front.sv @@
`timescale 1ns / 1ps

module stpe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  stpe_pkg::in_t   in_data,
	output logic            q_push,
	output stpe_pkg::job_t  q_wdata,
	input  logic            q_full
);
	import stpe_pkg::*;

	logic [BYTE_W-1:0] win_q [3];
	logic [1:0]        cnt_q;
	logic [1:0]        skip_q;
	logic              end_q;

	logic              work_left;
	logic              do_skip;
	logic              step_go;
	logic              enc_go;
	logic              in_acc;
	logic [BYTE_W-1:0] nxt;
	logic [BYTE_W-1:0] nxt1;
	class_t            cls;
	logic              enc_last;

	// a letter is worked off once two letters follow it, or at end of word
	assign work_left = (cnt_q != 2'd0) &&
		((skip_q != 2'd0) || (cnt_q == 2'd3) || end_q);
	assign do_skip   = skip_q != 2'd0;
	assign enc_go    = work_left && !do_skip && !q_full;
	assign step_go   = work_left && (do_skip || !q_full);

	assign in_stall  = work_left || q_full;
	assign in_acc    = in_valid && !in_stall;

	assign nxt  = (cnt_q > 2'd1) ? win_q[1] : '0;
	assign nxt1 = (cnt_q == 2'd3) ? win_q[2] : '0;
	assign cls  = classify(win_q[0], nxt, nxt1);

	// at end of word this letter is the last encoded one when the rule eats
	// every letter still behind it
	assign enc_last = end_q && ((cnt_q - 2'd1) <= cls.used);

	assign q_push = enc_go || (in_acc && in_data.verbatim);

	always_comb begin
		if (enc_go) begin
			q_wdata.pat  = cls.pat;
			q_wdata.c    = win_q[0];
			q_wdata.n    = nxt;
			q_wdata.last = enc_last;
		end else begin
			q_wdata.pat  = PAT_SELF;
			q_wdata.c    = in_data.char_in;
			q_wdata.n    = '0;
			q_wdata.last = in_data.end_of_word;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
		end else if (in_acc && !in_data.verbatim) begin
			win_q[cnt_q] <= in_data.char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			skip_q <= 2'd0;
			end_q  <= 1'b0;
		end else if (step_go) begin
			cnt_q  <= cnt_q - 2'd1;
			skip_q <= do_skip ? skip_q - 2'd1 : cls.used;
		end else if (!work_left) begin
			if (in_acc && !in_data.verbatim) begin
				cnt_q  <= cnt_q + 2'd1;
				skip_q <= end_q ? 2'd0 : skip_q;
				end_q  <= in_data.end_of_word;
			end else if ((in_acc && in_data.end_of_word) || end_q) begin
				cnt_q  <= 2'd0;
				skip_q <= 2'd0;
				end_q  <= 1'b0;
			end
		end
	end

	a_idle_window: assert property (@(posedge clk) disable iff (!arst_n)
		!work_left |-> cnt_q != 2'd3)
		else $error("window full but no work pending");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_data.verbatim |=> cnt_q != 2'd0)
		else $error("letter accepted but window empty");

endmodule

@@ rtl/stpe_fifo.sv @@
`timescale 1ns / 1ps

module stpe_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stpe_pkg::job_t  wdata,
	output logic            full,
	input  logic            pop,
	output stpe_pkg::job_t  rdata,
	output logic            empty
);
	import stpe_pkg::*;

	job_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  count_q;

	assign full  = count_q == FIFO_CW'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/stpe_back.sv @@
`timescale 1ns / 1ps

module stpe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  stpe_pkg::job_t  q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output stpe_pkg::out_t  out_data,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data
);
	import stpe_pkg::*;

	logic [BYTE_W-1:0] umlaut_q;
	logic              busy_q;
	job_t              job_q;
	logic [REM_W-1:0]  rem_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              emit;
	logic              job_done;
	logic [STR_W-1:0]  str;
	logic [BYTE_W-1:0] raw;
	logic [BYTE_W-1:0] obyte;

	assign emit     = busy_q && (!out_valid_q || !out_stall);
	assign job_done = emit && (rem_q == '0);
	assign q_pop    = !q_empty && (!busy_q || job_done);

	// characters go out from the top of the string downwards
	assign str = pat_str(job_q.pat);
	assign raw = str[{rem_q, 3'b000} +: BYTE_W];

	always_comb begin
		if (raw == UMLAUT_MARK) obyte = umlaut_q;
		else if (raw == NEXT_MARK) obyte = job_q.n;
		else if (raw == SELF_MARK) obyte = job_q.c;
		else obyte = raw;
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_rdata;
		if (emit) begin
			out_q.out_byte     <= obyte;
			out_q.last_of_word <= job_q.last && (rem_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			umlaut_q    <= UMLAUT_RESET;
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) umlaut_q <= cfg_wr_data;
			if (q_pop) begin
				busy_q <= 1'b1;
				rem_q  <= pat_top(q_rdata.pat);
			end else if (job_done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				rem_q <= rem_q - 1'b1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/spelling_tolerant_pattern_encoder.sv @@
`timescale 1ns / 1ps
// Spelling-tolerant pattern encoder.
// Input channel (in_valid / in_stall / in_data): one byte of a lower-case word
// per beat, end_of_word on the final byte, verbatim to copy bytes unchanged.
// Output channel (out_valid / out_stall / out_data): the pattern, one byte per
// beat, last_of_word on the final pattern byte of the word.
// cfg_wr_en / cfg_wr_data write the u-umlaut byte (252 after reset) used in the
// i and y letter classes; write it only while the block is idle.
// A letter is encoded once two letters behind it have arrived or the word ends.
// The front end takes a byte, then works off each letter that is ready (encoded
// or dropped) before it takes the next one; copied bytes go in one per cycle
// while no letter waits to be worked off and the queue is not full. Each encoded
// letter is one job in a four-entry queue. The back end expands a job at one
// output byte per cycle while the receiver does not stall, 1 to 12 beats per
// letter. The first output byte of a letter passes the window, the queue, the
// job register and the output register (a copied byte skips the window); it
// comes later when dropped letters or a busy back end come first.
// While the receiver stalls, the output register holds its beat, the back end
// waits, the queue fills and then in_stall rises. Reset empties the window,
// the queue and the output register.

module spelling_tolerant_pattern_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  stpe_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output stpe_pkg::out_t  out_data,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data
);
	import stpe_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	stpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	stpe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	stpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
